// ----- sv/ecgpd_pkg.sv -----
// ---------------------------------------------------------------------------
// ecgpd_pkg: shared types and constants for the ECG peak detector
// Payload structs, register indexes, reset values and back end states.
// ---------------------------------------------------------------------------
`default_nettype none
package ecgpd_pkg;

	localparam int MAX_WINDOW_DEF = 512;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int WIN_W      = 10;

	localparam logic signed [15:0] PEAK_THRESHOLD_RST = 16'sd492;
	localparam logic [WIN_W-1:0]   WINDOW_LENGTH_RST  = 10'd500;
	localparam logic [15:0]        AMP_LIMIT_RST      = 16'd27;
	localparam logic [31:0]        TACHY_LIMIT_RST    = 32'd600;
	localparam logic [31:0]        BRADY_LIMIT_RST    = 32'd1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PEAK_THRESHOLD = 3'd0,
		CFG_WINDOW_LENGTH  = 3'd1,
		CFG_AMP_LIMIT      = 3'd2,
		CFG_TACHY_LIMIT    = 3'd3,
		CFG_BRADY_LIMIT    = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		RHY_NORMAL = 2'd0,
		RHY_BRADY  = 2'd1,
		RHY_TACHY  = 2'd2
	} rhythm_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_HELD,
		BK_NEW
	} bk_state_t;

	typedef struct packed {
		logic signed [15:0] voltage_sample;
		logic [31:0]        sample_time;
	} in_item_t;

	typedef struct packed {
		logic [31:0]        peak_time;
		logic signed [15:0] peak_voltage;
		logic [1:0]         rhythm_class;
		logic               last_of_run;
	} out_item_t;

	typedef struct packed {
		logic signed [15:0] v;
		logic [31:0]        t;
	} peak_t;

endpackage
`default_nettype wire

// ----- sv/ecgpd_front.sv -----
// ---------------------------------------------------------------------------
// ecgpd_front: candidate detection and confirmation cell chain
// Judges the middle sample, tracks pending candidates, confirms peaks.
// ---------------------------------------------------------------------------
`default_nettype none
module ecgpd_front import ecgpd_pkg::*; #(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire in_item_t           sample,
	input  wire logic signed [15:0] peak_threshold,
	input  wire logic [WIN_W-1:0]   window_length,
	output logic                    peak_push,
	output peak_t                   peak
);

	localparam int LW = $clog2(MAX_WINDOW);

	logic                     vld_q  [MAX_WINDOW];
	logic signed [15:0]       cv_q   [MAX_WINDOW];
	logic [31:0]              ct_q   [MAX_WINDOW];
	logic [LW-1:0]            left_q [MAX_WINDOW];

	logic signed [15:0] old_v_q, mid_v_q;
	logic [31:0]        mid_t_q;
	logic               old_ok_q, mid_ok_q, refr_q;

	logic [MAX_WINDOW-1:0] keep, expire, load;
	logic                  cell_conf, cand, win_one, confirm;
	peak_t                 cell_peak;
	logic [31:0]           win32;
	logic [LW:0]           weff;
	logic [LW-1:0]         left_init;

	always_comb begin
		win32 = 32'(window_length);
		if (window_length == '0) begin
			weff = (LW+1)'(1);
		end else if (win32 > 32'(MAX_WINDOW)) begin
			weff = (LW+1)'(MAX_WINDOW);
		end else begin
			weff = (LW+1)'(win32);
		end
		left_init = LW'(weff - (LW+1)'(1));
		win_one   = (weff == (LW+1)'(1));
	end

	// drop cells the new sample exceeds; survivors form a prefix
	always_comb begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			keep[i]   = vld_q[i] && (sample.voltage_sample <= cv_q[i]);
			expire[i] = keep[i] && (left_q[i] == LW'(1));
		end
		cell_conf = |expire;
		cell_peak = '0;
		for (int i = MAX_WINDOW - 1; i >= 0; i--) begin
			if (expire[i]) begin
				cell_peak.v = cv_q[i];
				cell_peak.t = ct_q[i];
			end
		end
	end

	always_comb begin
		cand = !cell_conf && !refr_q && old_ok_q && mid_ok_q &&
			(mid_v_q >= peak_threshold) && (mid_v_q > old_v_q) &&
			(mid_v_q > sample.voltage_sample);
		confirm = cell_conf || (cand && win_one);
		for (int i = 0; i < MAX_WINDOW; i++) begin
			load[i] = cand && !win_one && !keep[i] && ((i == 0) || keep[(i == 0) ? 0 : i-1]);
		end
		peak_push = accept && confirm;
		if (cell_conf) begin
			peak = cell_peak;
		end else begin
			peak.v = mid_v_q;
			peak.t = mid_t_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_WINDOW; i++) begin
				vld_q[i] <= 1'b0;
			end
			old_ok_q <= 1'b0;
			mid_ok_q <= 1'b0;
			refr_q   <= 1'b0;
			old_v_q  <= '0;
			mid_v_q  <= '0;
			mid_t_q  <= '0;
		end else if (accept) begin
			for (int i = 0; i < MAX_WINDOW; i++) begin
				vld_q[i] <= !confirm && (keep[i] || load[i]);
			end
			refr_q   <= confirm;
			old_ok_q <= mid_ok_q;
			mid_ok_q <= 1'b1;
			old_v_q  <= mid_v_q;
			mid_v_q  <= sample.voltage_sample;
			mid_t_q  <= sample.sample_time;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < MAX_WINDOW; i++) begin
				if (load[i]) begin
					cv_q[i]   <= mid_v_q;
					ct_q[i]   <= mid_t_q;
					left_q[i] <= left_init;
				end else begin
					left_q[i] <= left_q[i] - LW'(1);
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/ecgpd_peak_q.sv -----
// ---------------------------------------------------------------------------
// ecgpd_peak_q: two-entry queue of confirmed peaks
// Decouples the detector from the classifier.
// ---------------------------------------------------------------------------
`default_nettype none
module ecgpd_peak_q import ecgpd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  wr,
	input  wire peak_t wr_data,
	output logic       full,
	input  wire logic  rd,
	output peak_t      rd_data,
	output logic       empty
);

	peak_t       mem_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr) wr_ptr_q <= !wr_ptr_q;
			if (rd) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule
`default_nettype wire

// ----- sv/ecgpd_back.sv -----
// ---------------------------------------------------------------------------
// ecgpd_back: rhythm classifier and result register
// Compares each peak with the previous one and emits classified results.
// ---------------------------------------------------------------------------
`default_nettype none
module ecgpd_back import ecgpd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_empty,
	input  wire peak_t       q_data,
	output logic             q_rd,
	input  wire logic [15:0] amp_limit,
	input  wire logic [31:0] tachy_limit,
	input  wire logic [31:0] brady_limit,
	input  wire logic        pop,
	output logic             empty,
	output out_item_t        result
);

	bk_state_t state_q, state_d;

	logic signed [15:0] prev_v_q, held_v_q, cur_v_q, eh_v_q;
	logic [31:0]        prev_t_q, held_t_q, cur_t_q, eh_t_q, iv_held_q, iv_new_q;
	logic               held_ok_q, big_q, out_vld_q;
	out_item_t          out_q;

	logic               slot_free, push_held, push_new, big;
	logic signed [16:0] dv;
	logic [16:0]        amp;

	function automatic logic [1:0] classify(input logic [31:0] iv,
		input logic [31:0] tl, input logic [31:0] bl);
		priority if (iv <= tl) return RHY_TACHY;
		else if (iv > bl) return RHY_BRADY;
		else return RHY_NORMAL;
	endfunction

	function automatic logic [31:0] tdiff(input logic [31:0] a, input logic [31:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	always_comb begin
		dv  = 17'(q_data.v) - 17'(prev_v_q);
		amp = dv[16] ? 17'(-dv) : 17'(dv);
		big = amp > {1'b0, amp_limit};
	end

	assign slot_free = !out_vld_q || pop;

	always_comb begin
		state_d   = state_q;
		q_rd      = 1'b0;
		push_held = 1'b0;
		push_new  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_rd = 1'b1;
					if (held_ok_q) state_d = BK_HELD;
					else if (!big) state_d = BK_NEW;
				end
			end
			BK_HELD: begin
				if (slot_free) begin
					push_held = 1'b1;
					state_d   = big_q ? BK_IDLE : BK_NEW;
				end
			end
			BK_NEW: begin
				if (slot_free) begin
					push_new = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			held_ok_q <= 1'b0;
			prev_v_q  <= '0;
			prev_t_q  <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_rd) begin
				held_ok_q <= big;
				prev_v_q  <= q_data.v;
				prev_t_q  <= q_data.t;
			end
			if (push_held || push_new) out_vld_q <= 1'b1;
			else if (pop)              out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			cur_v_q   <= q_data.v;
			cur_t_q   <= q_data.t;
			eh_v_q    <= held_v_q;
			eh_t_q    <= held_t_q;
			big_q     <= big;
			iv_held_q <= tdiff(held_t_q, q_data.t);
			iv_new_q  <= tdiff(q_data.t, prev_t_q);
			if (big) begin
				held_v_q <= q_data.v;
				held_t_q <= q_data.t;
			end
		end
		if (push_held) begin
			out_q.peak_time    <= eh_t_q;
			out_q.peak_voltage <= eh_v_q;
			out_q.rhythm_class <= classify(iv_held_q, tachy_limit, brady_limit);
			out_q.last_of_run  <= big_q;
		end else if (push_new) begin
			out_q.peak_time    <= cur_t_q;
			out_q.peak_voltage <= cur_v_q;
			out_q.rhythm_class <= classify(iv_new_q, tachy_limit, brady_limit);
			out_q.last_of_run  <= 1'b1;
		end
	end

	assign empty  = !out_vld_q;
	assign result = out_q;

endmodule
`default_nettype wire

// ----- sv/ecg_peak_detect_rhythm_classify.sv -----
// ---------------------------------------------------------------------------
// ecg_peak_detect_rhythm_classify: R-peak detector with RR rhythm classes
// Top level: configuration registers, detector, peak queue, classifier.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: drive sample and raise push; a request is taken at a
//   clock edge with push high and full low. One sample per cycle is taken
//   as long as the peak queue has room.
//   Result channel: while empty is low, result holds the oldest classified
//   peak; raise pop to take it. Each sample gives zero, one or two results;
//   last_of_run marks the final one of a sample.
//   Path: a confirmed peak reaches the result port through the peak queue
//   and the classifier FSM, which takes a peak in BK_IDLE and emits each
//   result from BK_HELD or BK_NEW.
//   The candidate cell chain checks all pending candidates each cycle.
//   Stall: if pop stays low the result register holds, the classifier
//   waits, the two-entry peak queue fills and full rises.
//   Reset (arst_n low): registers take their default values, all cells
//   and queues empty; no clearing pass is needed.
//   Configuration: write through cfg_we / cfg_idx / cfg_data while idle.
// ---------------------------------------------------------------------------
`default_nettype none
module ecg_peak_detect_rhythm_classify import ecgpd_pkg::*; #(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire in_item_t              sample,
	output logic                       empty,
	input  wire logic                  pop,
	output out_item_t                  result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic signed [15:0] peak_threshold_q;
	logic [WIN_W-1:0]   window_length_q;
	logic [15:0]        amp_limit_q;
	logic [31:0]        tachy_limit_q, brady_limit_q;

	logic  accept, peak_push, q_rd, q_empty;
	peak_t peak, q_data;

	// hold each register until a write addresses it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_threshold_q <= PEAK_THRESHOLD_RST;
			window_length_q  <= WINDOW_LENGTH_RST;
			amp_limit_q      <= AMP_LIMIT_RST;
			tachy_limit_q    <= TACHY_LIMIT_RST;
			brady_limit_q    <= BRADY_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_PEAK_THRESHOLD: peak_threshold_q <= cfg_data[15:0];
				CFG_WINDOW_LENGTH:  window_length_q  <= cfg_data[WIN_W-1:0];
				CFG_AMP_LIMIT:      amp_limit_q      <= cfg_data[15:0];
				CFG_TACHY_LIMIT:    tachy_limit_q    <= cfg_data[31:0];
				CFG_BRADY_LIMIT:    brady_limit_q    <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// take a request only while the peak queue can absorb a confirmation
	assign accept = push && !full;

	ecgpd_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.sample         (sample),
		.peak_threshold (peak_threshold_q),
		.window_length  (window_length_q),
		.peak_push      (peak_push),
		.peak           (peak)
	);

	ecgpd_peak_q u_peak_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (peak_push),
		.wr_data (peak),
		.full    (full),
		.rd      (q_rd),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	ecgpd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_data      (q_data),
		.q_rd        (q_rd),
		.amp_limit   (amp_limit_q),
		.tachy_limit (tachy_limit_q),
		.brady_limit (brady_limit_q),
		.pop         (pop),
		.empty       (empty),
		.result      (result)
	);

endmodule
`default_nettype wire

// ----- sv/ecgpd_checker.sv -----
// ---------------------------------------------------------------------------
// ecgpd_checker: port-level checks for the ECG peak detector
// Watches the result channel and reset behavior.
// ---------------------------------------------------------------------------
`default_nettype none
module ecgpd_checker import ecgpd_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      full,
	input wire logic      empty,
	input wire logic      pop,
	input wire out_item_t result
);

	a_reset_idle: assert property (@(posedge clk) $rose(arst_n) |-> empty && !full)
		else $error("queues not empty after reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("stalled result changed");

	a_class: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.rhythm_class != 2'd3)
		else $error("illegal rhythm class");

	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !result.last_of_run |=> !empty)
		else $error("second result of a sample missing");

endmodule

bind ecg_peak_detect_rhythm_classify ecgpd_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
`default_nettype wire
